[src/epd_pkg.sv]
// ----------------------------------------------------------------------------
// epd_pkg
// Types and constants shared by the encoder position PID drive modules.
// ----------------------------------------------------------------------------
package epd_pkg;

  typedef struct packed {
    logic kind;
    logic direction_level;
  } epd_in_t;

  typedef struct packed {
    logic               item_kind;
    logic signed [31:0] encoder_count;
    logic [7:0]         duty;
    logic               drive_forward;
    logic               drive_reverse;
  } epd_out_t;

  localparam int unsigned ERR_W     = 42;  // stored error, whole degrees
  localparam int unsigned OUT_W     = 40;  // controller output, Q24.16
  localparam int unsigned COEF_W    = 53;  // alpha, beta, gamma at 2^-40
  localparam int unsigned ACC_W     = 96;  // numerator and divider dividend
  localparam int unsigned DVS_W     = 25;  // divisor width (period << 9)
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned DIV_STEPS = ACC_W;
  localparam int unsigned MAC_STEPS = ERR_W;
  localparam int unsigned STEP_W    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd4;

  localparam logic [1:0] TERM_NOW   = 2'd0;
  localparam logic [1:0] TERM_PREV  = 2'd1;
  localparam logic [1:0] TERM_PREV2 = 2'd2;

  typedef struct packed {
    logic       edge_step;
    logic       pos_load;
    logic       div_step;
    logic       err_calc;
    logic       coef1;
    logic       coef2;
    logic       mac_load;
    logic [1:0] term;
    logic       mac_step;
    logic       num_load;
    logic       update;
  } epd_cmd_t;

endpackage

[src/epd_ctrl.sv]
// ----------------------------------------------------------------------------
// epd_ctrl
// Sequencer: accepts items, steps the shared divider and MAC, owns out_valid.
// ----------------------------------------------------------------------------
module epd_ctrl import epd_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output epd_cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE, POS_MUL, ERR, COEF1, COEF2, MAC_LOAD, MAC_RUN, NUM_LOAD, NUM_DIV, UPDATE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [1:0]        term;
  logic              in_fire;
  logic              slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.term      = term;
    cmd.edge_step = in_fire && !in_kind;
    cmd.pos_load  = in_fire && in_kind;
    cmd.div_step  = (state == NUM_DIV);
    cmd.err_calc  = (state == ERR);
    cmd.coef1     = (state == COEF1);
    cmd.coef2     = (state == COEF2);
    cmd.mac_load  = (state == MAC_LOAD);
    cmd.mac_step  = (state == MAC_RUN) || (state == POS_MUL);
    cmd.num_load  = (state == NUM_LOAD);
    cmd.update    = (state == UPDATE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step      <= '0;
      term      <= TERM_NOW;
      out_valid <= 1'b0;
    end else begin
      if (cmd.edge_step || cmd.update) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.pos_load) begin
            state <= POS_MUL;
            step  <= '0;
          end
        end
        // one shift-add step per count bit
        POS_MUL: begin
          step <= step + 1'b1;
          if (step == STEP_W'(COUNT_WIDTH - 1)) state <= ERR;
        end
        ERR:   state <= COEF1;
        COEF1: state <= COEF2;
        COEF2: begin
          term  <= TERM_NOW;
          state <= MAC_LOAD;
        end
        MAC_LOAD: begin
          step  <= '0;
          state <= MAC_RUN;
        end
        MAC_RUN: begin
          step <= step + 1'b1;
          if (step == STEP_W'(MAC_STEPS - 1)) begin
            if (term == TERM_PREV2) begin
              state <= NUM_LOAD;
            end else begin
              term  <= term + 1'b1;
              state <= MAC_LOAD;
            end
          end
        end
        NUM_LOAD: begin
          step  <= '0;
          state <= NUM_DIV;
        end
        NUM_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) state <= UPDATE;
        end
        UPDATE: begin
          if (slot_free) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> !in_ready) else $error("input taken while busy");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !(state == IDLE)) |=> out_valid)
    else $error("result dropped before taken");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.edge_step, cmd.pos_load, cmd.div_step, cmd.err_calc, cmd.coef1,
              cmd.coef2, cmd.mac_load, cmd.mac_step, cmd.num_load, cmd.update}))
    else $error("overlapping datapath commands");

  a_update_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (!out_valid || out_ready)) else $error("result overwritten");

endmodule

[src/epd_dpath.sv]
// ----------------------------------------------------------------------------
// epd_dpath
// Encoder count, PID state, bit-serial MAC, restoring divider, result register.
// ----------------------------------------------------------------------------
module epd_dpath import epd_pkg::*; #(
  parameter int COUNT_WIDTH      = 32,
  parameter int DRIVE_LIMIT      = 255,
  parameter int PULSES_PER_SCALE = 1250
) (
  input  logic               clk,
  input  logic               rst,
  input  epd_cmd_t           cmd,
  input  logic               direction_level,
  input  logic [15:0]        gain_proportional,
  input  logic [15:0]        gain_integral,
  input  logic [15:0]        gain_derivative,
  input  logic [15:0]        sample_period,
  input  logic signed [15:0] target_degrees,
  output epd_out_t           result
);

  localparam int PM_W = COUNT_WIDTH + 9;
  localparam int DF_W = (PM_W + 2 > ERR_W + 1) ? PM_W + 2 : ERR_W + 1;
  // position = |count| * RECIP >> RS, exact for every count magnitude
  localparam int PD_LOG = $clog2(PULSES_PER_SCALE);
  localparam int RS     = COUNT_WIDTH + PD_LOG;
  localparam int AW     = (2 * COUNT_WIDTH + 10 > ACC_W) ? 2 * COUNT_WIDTH + 10 : ACC_W;
  localparam int EW     = (COUNT_WIDTH > ERR_W) ? COUNT_WIDTH : ERR_W;
  localparam logic [127:0] RECIP_X =
    ((128'(360) << RS) + 128'(PULSES_PER_SCALE - 1)) / 128'(PULSES_PER_SCALE);
  localparam logic signed [AW-1:0] RECIP = AW'(RECIP_X);
  localparam logic signed [DF_W-1:0] E_HI = DF_W'($signed({1'b0, {(ERR_W-1){1'b1}}}));
  localparam logic signed [DF_W-1:0] E_LO = DF_W'($signed({1'b1, {(ERR_W-1){1'b0}}}));
  localparam logic signed [OUT_W-1:0] O_HI = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] O_LO = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic signed [OUT_W:0] S_HI = {2'b00, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W:0] S_LO = {2'b11, {(OUT_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] LIM = OUT_W'(DRIVE_LIMIT) << 16;

  // state
  logic [COUNT_WIDTH-1:0]   count;
  logic signed [ERR_W-1:0]  err0, err1, err2;
  logic signed [OUT_W-1:0]  outp;
  logic [7:0]               duty_held;

  // working registers
  logic                     cnt_neg, acc_neg;
  logic [ACC_W-1:0]         dvd;
  logic [DVS_W-1:0]         dvs, rem;
  logic [31:0]              tkp, tt;
  logic [47:0]              itt;
  logic signed [AW-1:0]     acc, mreg;
  logic [EW-1:0]            ereg;

  logic [COUNT_WIDTH-1:0]   cnt_mag, cnt_next;
  logic [PM_W-1:0]          pos_mag;
  logic [15:0]              t;
  logic [DVS_W:0]           trial;
  logic                     ge;
  logic signed [DF_W-1:0]   tgt_w, pos_w, diff;
  logic signed [ERR_W-1:0]  e_sat, e_sel;
  logic [ERR_W-1:0]         e_mag;
  logic signed [COEF_W-1:0] alpha, beta, gamma, c_sel;
  logic signed [AW-1:0]     c_ext;
  logic                     q_big;
  logic signed [OUT_W-1:0]  inc, o_new, c_clamp, c_mag;
  logic signed [OUT_W:0]    o_sum;

  assign cnt_mag  = count[COUNT_WIDTH-1] ? (~count + 1'b1) : count;
  assign cnt_next = direction_level ? count - 1'b1 : count + 1'b1;
  assign t        = (sample_period == 16'd0) ? 16'd1 : sample_period;

  assign trial = {rem, dvd[ACC_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  // position from the reciprocal product, then the saturated error
  assign pos_mag = PM_W'(acc >> RS);
  assign tgt_w = DF_W'(target_degrees);
  assign pos_w = cnt_neg ? -$signed(DF_W'(pos_mag)) : $signed(DF_W'(pos_mag));
  assign diff  = tgt_w - pos_w;
  assign e_sat = (diff > E_HI) ? ERR_W'(E_HI) : (diff < E_LO) ? ERR_W'(E_LO) : ERR_W'(diff);

  assign alpha = COEF_W'({tkp, 17'b0}) + COEF_W'(itt) + COEF_W'({gain_derivative, 33'b0});
  assign beta  = COEF_W'(itt) - COEF_W'({gain_derivative, 34'b0}) - COEF_W'({tkp, 17'b0});
  assign gamma = COEF_W'({gain_derivative, 33'b0});

  always_comb begin
    case (cmd.term)
      TERM_NOW: begin
        c_sel = alpha;
        e_sel = err0;
      end
      TERM_PREV: begin
        c_sel = beta;
        e_sel = err1;
      end
      default: begin
        c_sel = gamma;
        e_sel = err2;
      end
    endcase
  end

  assign e_mag = e_sel[ERR_W-1] ? ERR_W'(-e_sel) : ERR_W'(e_sel);
  assign c_ext = AW'(c_sel);

  // quotient saturates to the output range, then the output itself
  assign q_big   = |dvd[ACC_W-1:OUT_W-1];
  assign inc     = acc_neg ? (q_big ? O_LO : -$signed(dvd[OUT_W-1:0]))
                           : (q_big ? O_HI : $signed(dvd[OUT_W-1:0]));
  assign o_sum   = (OUT_W+1)'(outp) + (OUT_W+1)'(inc);
  assign o_new   = (o_sum > S_HI) ? O_HI : (o_sum < S_LO) ? O_LO : OUT_W'(o_sum);
  assign c_clamp = (o_new > LIM) ? LIM : (o_new < -LIM) ? -LIM : o_new;
  assign c_mag   = c_clamp[OUT_W-1] ? -c_clamp : c_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err0      <= '0;
      err1      <= '0;
      err2      <= '0;
      outp      <= '0;
      duty_held <= '0;
    end else begin
      if (cmd.edge_step) count <= cnt_next;
      if (cmd.err_calc) err0 <= e_sat;
      if (cmd.update) begin
        outp <= o_new;
        err2 <= err1;
        err1 <= err0;
        if (c_clamp != '0) duty_held <= c_mag[23:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.num_load) begin
      acc_neg <= acc[AW-1];
      dvd     <= acc[AW-1] ? ACC_W'(-acc) : ACC_W'(acc);
      dvs     <= {t, 9'b0};
      rem     <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      dvd <= {dvd[ACC_W-2:0], ge};
    end
    if (cmd.coef1) begin
      tkp <= t * gain_proportional;
      tt  <= t * t;
      acc <= '0;
    end
    if (cmd.coef2) itt <= gain_integral * tt;
    if (cmd.pos_load) begin
      cnt_neg <= count[COUNT_WIDTH-1];
      mreg    <= RECIP;
      ereg    <= EW'(cnt_mag);
      acc     <= '0;
    end else if (cmd.mac_load) begin
      mreg <= e_sel[ERR_W-1] ? -c_ext : c_ext;
      ereg <= EW'(e_mag);
    end else if (cmd.mac_step) begin
      if (ereg[0]) acc <= acc + mreg;
      mreg <= mreg <<< 1;
      ereg <= ereg >> 1;
    end
    if (cmd.edge_step) begin
      result.item_kind     <= 1'b0;
      result.encoder_count <= 32'($signed(cnt_next));
      result.duty          <= duty_held;
      result.drive_forward <= 1'b0;
      result.drive_reverse <= 1'b0;
    end else if (cmd.update) begin
      result.item_kind     <= 1'b1;
      result.encoder_count <= 32'($signed(count));
      result.duty          <= (c_clamp != '0) ? c_mag[23:16] : duty_held;
      result.drive_forward <= (c_clamp > 0);
      result.drive_reverse <= c_clamp[OUT_W-1];
    end
  end

endmodule

[src/encoder_position_pid_drive.sv]
// ----------------------------------------------------------------------------
// encoder_position_pid_drive
// Encoder pulse counter with an incremental Tustin-form PID position loop.
//
// in_data carries one beat per item: an encoder edge (kind 0) moves the
// signed count by one, down when direction_level is high; a control tick
// (kind 1) runs one PID step and updates duty and the drive bits.
// Every item gives exactly one beat on out_data.
// An edge beat is ready on the cycle after acceptance, so edges can follow
// one per cycle while the receiver keeps taking results. A tick's beat
// follows these steps: COUNT_WIDTH shift-add steps multiply the count by a
// reciprocal for the position, set-up of the error and the coefficients,
// three MAC passes for the numerator, a load and 96 restoring divider steps
// for the increment, and the update. One item is in work at a time; in_ready
// is high only when the sequencer is idle and the result register is empty
// or being taken. When the receiver stalls, the result is held and no new
// item is taken. Reset clears the count, the error history, the output and
// the held duty, and loads the register defaults. cfg_ready is always high;
// a write to an unlisted index is dropped.
// ----------------------------------------------------------------------------
module encoder_position_pid_drive import epd_pkg::*; #(
  parameter int COUNT_WIDTH      = 32,
  parameter int DRIVE_LIMIT      = 255,
  parameter int PULSES_PER_SCALE = 1250
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  epd_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output epd_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [15:0]        gain_proportional, gain_integral, gain_derivative, sample_period;
  logic signed [15:0] target_degrees;
  epd_cmd_t           cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_proportional <= 16'd256;
      gain_integral     <= 16'd0;
      gain_derivative   <= 16'd0;
      sample_period     <= 16'd655;
      target_degrees    <= 16'sd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KP:     gain_proportional <= cfg_data;
        REG_KI:     gain_integral     <= cfg_data;
        REG_KD:     gain_derivative   <= cfg_data;
        REG_PERIOD: sample_period     <= cfg_data;
        REG_TARGET: target_degrees    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  epd_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  epd_dpath #(
    .COUNT_WIDTH      (COUNT_WIDTH),
    .DRIVE_LIMIT      (DRIVE_LIMIT),
    .PULSES_PER_SCALE (PULSES_PER_SCALE)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .direction_level   (in_data.direction_level),
    .gain_proportional (gain_proportional),
    .gain_integral     (gain_integral),
    .gain_derivative   (gain_derivative),
    .sample_period     (sample_period),
    .target_degrees    (target_degrees),
    .result            (out_data)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives encoder edges and control ticks into the PID drive under random
// idling on both channels, predicts every result beat with a local fixed-point
// model of the count and the Tustin PID step, and checks each beat in order.
// ----------------------------------------------------------------------------
module testbench;
  import epd_pkg::*;

  localparam int           WATCHDOG_LIMIT = 6000;
  localparam logic         KIND_EDGE      = 1'b0;
  localparam logic         KIND_TICK      = 1'b1;
  localparam longint       OUT_HI         = 64'sd549755813887;
  localparam longint       OUT_LO         = -64'sd549755813888;
  localparam longint       ERR_HI         = 64'sd2199023255551;
  localparam longint       ERR_LO         = -64'sd2199023255552;
  localparam longint       CLAMP          = 64'sd255 * 64'sd65536;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  epd_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  epd_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  encoder_position_pid_drive u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // drive model state and registers
  logic [31:0]        pulses;
  longint             err_1;
  longint             err_2;
  longint             out_last;
  logic [7:0]         duty_last;
  logic [15:0]        kp_reg;
  logic [15:0]        ki_reg;
  logic [15:0]        kd_reg;
  logic [15:0]        period_reg;
  logic signed [15:0] target_reg;

  epd_out_t pending_beats[$];
  int       errors;
  int       idle_cycles;
  int       hold_off;
  int       ready_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic advance_drive(input epd_in_t beat);
    epd_out_t                r;
    logic signed [31:0]      cnt;
    logic [63:0]             mag;
    longint                  pos;
    longint                  e;
    logic [63:0]             t;
    logic [63:0]             tkp;
    logic [63:0]             itt;
    logic signed [63:0]      alpha;
    logic signed [63:0]      beta;
    logic signed [63:0]      gamma;
    logic signed [127:0]     num;
    logic signed [127:0]     q;
    longint                  inc;
    longint                  o;
    longint                  c;
    r = '0;
    r.item_kind = beat.kind;
    if (beat.kind == KIND_EDGE) begin
      pulses = beat.direction_level ? pulses - 32'd1 : pulses + 32'd1;
    end else begin
      cnt = pulses;
      mag = (cnt < 0) ? 64'(-64'(cnt)) : 64'(cnt);
      mag = mag * 64'd360 / 64'd1250;
      pos = (cnt < 0) ? -longint'(mag) : longint'(mag);
      e = clip(longint'(target_reg) - pos, ERR_LO, ERR_HI);
      t = (period_reg == 16'd0) ? 64'd1 : 64'(period_reg);
      tkp = t * 64'(kp_reg);
      itt = 64'(ki_reg) * t * t;
      alpha = (tkp << 17) + itt + (64'(kd_reg) << 33);
      beta = $signed(itt) - $signed(64'(kd_reg) << 34) - $signed(tkp << 17);
      gamma = 64'(kd_reg) << 33;
      num = 128'(alpha) * 128'(e) + 128'(beta) * 128'(err_1) + 128'(gamma) * 128'(err_2);
      q = num / $signed(128'(t << 9));
      if (q > 128'sd549755813887) inc = OUT_HI;
      else if (q < -128'sd549755813888) inc = OUT_LO;
      else inc = longint'(q);
      o = clip(out_last + inc, OUT_LO, OUT_HI);
      c = clip(o, -CLAMP, CLAMP);
      out_last = o;
      err_2 = err_1;
      err_1 = e;
      if (c != 0) begin
        duty_last = 8'(((c < 0) ? -c : c) >>> 16);
        r.drive_forward = (c > 0);
        r.drive_reverse = (c < 0);
      end
    end
    r.encoder_count = pulses;
    r.duty = duty_last;
    pending_beats.push_back(r);
  endtask

  // model update on every accepted beat, in the order the block sees them
  always @(posedge clk) begin
    if (rst) begin
      pulses = '0; err_1 = 0; err_2 = 0; out_last = 0; duty_last = '0;
      kp_reg = 16'd256; ki_reg = '0; kd_reg = '0; period_reg = 16'd655; target_reg = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KP:     kp_reg = cfg_data;
          REG_KI:     ki_reg = cfg_data;
          REG_KD:     kd_reg = cfg_data;
          REG_PERIOD: period_reg = cfg_data;
          REG_TARGET: target_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_drive(in_data);
    end
  end

  // result checker
  always @(posedge clk) begin
    epd_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %p", $time, out_data);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (out_data.item_kind !== want.item_kind) begin
          $display("%0t: item_kind expected %0d got %0d", $time, want.item_kind,
                   out_data.item_kind);
          errors++;
        end
        if (out_data.encoder_count !== want.encoder_count) begin
          $display("%0t: encoder_count expected %0d got %0d", $time, want.encoder_count,
                   out_data.encoder_count);
          errors++;
        end
        if (out_data.duty !== want.duty) begin
          $display("%0t: duty expected %0d got %0d", $time, want.duty, out_data.duty);
          errors++;
        end
        if (out_data.drive_forward !== want.drive_forward) begin
          $display("%0t: drive_forward expected %0d got %0d", $time, want.drive_forward,
                   out_data.drive_forward);
          errors++;
        end
        if (out_data.drive_reverse !== want.drive_reverse) begin
          $display("%0t: drive_reverse expected %0d got %0d", $time, want.drive_reverse,
                   out_data.drive_reverse);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, mostly short, a few long, plus a requested hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_idle = 0;
    end else if (hold_off > 0) begin
      hold_off = hold_off - 1;
      out_ready <= 1'b0;
    end else if (ready_idle > 0) begin
      ready_idle = ready_idle - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      ready_idle = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic send_item(input logic kind, input logic dir, input bit no_gap = 0);
    int gap;
    gap = 0;
    if (!no_gap && $urandom_range(0, 99) < 35)
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: kind, direction_level: dir};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_gains(input logic [15:0] kp, input logic [15:0] ki,
                            input logic [15:0] kd, input logic [15:0] per,
                            input logic [15:0] tgt);
    drain_results();
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_PERIOD, per);
    write_reg(REG_TARGET, tgt);
  endtask

  // runs of mostly same-direction edges move the count, ticks close the loop
  task automatic random_items(input int n);
    int  i;
    int  run;
    logic dir;
    i = 0;
    while (i < n) begin
      if ($urandom_range(0, 99) < 60) begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
        dir = 1'($urandom_range(0, 1));
        repeat (run) begin
          send_item(KIND_EDGE, ($urandom_range(0, 9) == 0) ? ~dir : dir);
          i++;
        end
      end else begin
        send_item(KIND_TICK, 1'($urandom_range(0, 1)));
        i++;
      end
    end
  endtask

  task automatic test_edges_and_reset_gains;
    send_item(KIND_TICK, 1'b0);
    send_item(KIND_EDGE, 1'b0);
    send_item(KIND_EDGE, 1'b0);
    send_item(KIND_EDGE, 1'b1);
    repeat (5) send_item(KIND_EDGE, 1'b1);
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_TICK, 1'b0);
    repeat (8) send_item(KIND_EDGE, 1'b0);
    send_item(KIND_TICK, 1'b0);
  endtask

  // tiny gain gives a sub-unit drive: drive bit set, duty zero
  task automatic test_small_drive;
    load_gains(16'd1, 16'd0, 16'd0, 16'd655, 16'd1);
    send_item(KIND_TICK, 1'b0);
    load_gains(16'd1, 16'd0, 16'd0, 16'd655, 16'hFFFF);
    send_item(KIND_TICK, 1'b0);
    send_item(KIND_TICK, 1'b0);
  endtask

  task automatic test_extremes;
    load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    repeat (3) send_item(KIND_TICK, 1'b0);
    load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'h8000);
    repeat (3) send_item(KIND_TICK, 1'b1);
    load_gains(16'd0, 16'd0, 16'd0, 16'd1, 16'd0);
    send_item(KIND_TICK, 1'b0);
  endtask

  task automatic test_random_settings;
    int p;
    for (p = 0; p < 12; p++) begin
      case (p % 4)
        0: load_gains(16'd256, 16'd0, 16'd0, 16'd655, 16'($urandom_range(0, 200)));
        1: load_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
        2: load_gains(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 512)),
                      16'($urandom_range(0, 64)), 16'($urandom_range(1, 4000)),
                      16'($signed($urandom_range(0, 400)) - 200));
        default: load_gains(16'($urandom_range(0, 1) ? 16'hFFFF : 16'd0),
                            16'($urandom_range(0, 1) ? 16'hFFFF : 16'd0),
                            16'($urandom_range(0, 1) ? 16'hFFFF : 16'd0),
                            16'($urandom_range(0, 1) ? 16'hFFFF : 16'd1),
                            16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000));
      endcase
      random_items(140);
    end
  endtask

  // long receiver hold-off while items keep coming back to back
  task automatic test_backpressure;
    load_gains(16'd512, 16'd16, 16'd4, 16'd655, 16'd30);
    hold_off = 800;
    repeat (30) send_item($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), 1'b1);
    random_items(80);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    hold_off = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges_and_reset_gains();
    test_small_drive();
    test_extremes();
    test_random_settings();
    test_backpressure();
    drain_results();
    repeat (400) @(posedge clk);
    if (errors == 0 && pending_beats.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

[encoder_position_pid_drive.f]
src/epd_pkg.sv
src/epd_ctrl.sv
src/epd_dpath.sv
src/encoder_position_pid_drive.sv
verif/testbench.sv
